// ----- src/beq_pkg.sv -----
package beq_pkg;

    localparam int TIME_W    = 32;
    localparam int CNT_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE        = 3'd0,
        REG_INVERT        = 3'd1,
        REG_NOISE_GATE    = 3'd2,
        REG_DEBOUNCE      = 3'd3,
        REG_LONGPRESS     = 3'd4,
        REG_REPEAT_WINDOW = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic              enable;
        logic              invert_polarity;
        logic [TIME_W-1:0] noise_gate_ms;
        logic [TIME_W-1:0] debounce_ms;
        logic [TIME_W-1:0] longpress_ms;
        logic [TIME_W-1:0] repeat_window_ms;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0] gate_start;
        logic [TIME_W-1:0] last_change_time;
        logic              down_level;
        logic [CNT_W-1:0]  hold_count;
        logic [TIME_W-1:0] hold_mark_time;
        logic [CNT_W-1:0]  repeat_tally;
    } t_state;

    typedef struct packed {
        logic              is_down;
        logic              down_changed;
        logic [TIME_W-1:0] change_period_ms;
        logic [CNT_W-1:0]  repeat_count;
        logic [CNT_W-1:0]  longpress_count;
    } t_result;

endpackage

// ----- src/beq_cfg.sv -----
module beq_cfg
    import beq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                REG_ENABLE:        n_cfg.enable           = i_cfg_data[0];
                REG_INVERT:        n_cfg.invert_polarity  = i_cfg_data[0];
                REG_NOISE_GATE:    n_cfg.noise_gate_ms    = i_cfg_data[TIME_W-1:0];
                REG_DEBOUNCE:      n_cfg.debounce_ms      = i_cfg_data[TIME_W-1:0];
                REG_LONGPRESS:     n_cfg.longpress_ms     = i_cfg_data[TIME_W-1:0];
                REG_REPEAT_WINDOW: n_cfg.repeat_window_ms = i_cfg_data[TIME_W-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- src/beq_eval.sv -----
module beq_eval
    import beq_pkg::*;
(
    input  t_cfg              i_cfg,
    input  t_state            i_state,
    input  logic [TIME_W-1:0] i_now,
    input  logic              i_raw,
    output t_state            o_state,
    output logic              o_emit,
    output t_result           o_result
);

    logic              down;
    logic              go;
    logic              changed;
    logic              lp_changed;
    logic [TIME_W-1:0] since;
    logic [TIME_W-1:0] gate_age;
    logic [TIME_W-1:0] hold_age;

    assign down     = i_cfg.invert_polarity ? i_raw : ~i_raw;
    assign gate_age = i_now - i_state.gate_start;
    assign since    = i_now - i_state.last_change_time;
    assign hold_age = i_now - i_state.hold_mark_time;
    assign changed  = (down != i_state.down_level);

    always_comb begin
        o_state    = i_state;
        go         = i_cfg.enable;
        lp_changed = 1'b0;

        // noise gate
        if (go && (i_cfg.noise_gate_ms != '0)) begin
            if ((i_state.gate_start == '0) && down) begin
                o_state.gate_start = i_now;
                go = 1'b0;
            end else if ((gate_age < i_cfg.noise_gate_ms) && down) begin
                go = 1'b0;
            end else if ((i_state.gate_start != '0) && !down) begin
                o_state.gate_start = '0;
                go = 1'b0;
            end else begin
                o_state.gate_start = '0;
            end
        end

        if (go && (since < i_cfg.debounce_ms)) begin
            go = 1'b0;
        end

        if (go) begin
            if (!down || changed) begin
                o_state.hold_count     = '0;
                o_state.hold_mark_time = i_now;
            end else if (hold_age > i_cfg.longpress_ms) begin
                if (i_state.hold_count != CNT_MAX) begin
                    o_state.hold_count = i_state.hold_count + 1'b1;
                    lp_changed = 1'b1;
                end
                o_state.hold_mark_time = i_now;
            end

            if (changed) begin
                o_state.last_change_time = i_now;
                o_state.down_level       = down;
                if (down && (i_state.last_change_time != '0)) begin
                    if (since < i_cfg.repeat_window_ms) begin
                        o_state.repeat_tally = (i_state.repeat_tally == CNT_MAX) ?
                            CNT_MAX : i_state.repeat_tally + 1'b1;
                    end else begin
                        o_state.repeat_tally = '0;
                    end
                end
            end
        end
    end

    assign o_emit                   = go && (changed || lp_changed);
    assign o_result.is_down         = o_state.down_level;
    assign o_result.down_changed    = changed;
    assign o_result.change_period_ms = since;
    assign o_result.repeat_count    = o_state.repeat_tally;
    assign o_result.longpress_count = o_state.hold_count;

endmodule

// ----- src/button_event_qualifier_top.sv -----
// channel | direction | handshake              | payload
// in      | sink      | i_in_valid / o_in_stall | i_now_ms, i_raw_level
// out     | source    | o_out_valid / i_out_stall | o_is_down .. o_longpress_count
// cfg     | sink      | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One beat per cycle sustained while the result side does not stall. An input
// beat waits in the input register; a qualifying one loads the result register.
// Reset (synchronous, active low) clears config, state and both valid flags.
// A stalled result register holds the input register, which then stalls in.
module button_event_qualifier_top
    import beq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [TIME_W-1:0]    i_now_ms,
    input  logic                 i_raw_level,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_is_down,
    output logic                 o_down_changed,
    output logic [TIME_W-1:0]    o_change_period_ms,
    output logic [CNT_W-1:0]     o_repeat_count,
    output logic [CNT_W-1:0]     o_longpress_count,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cfg              cfg;
    t_state            r_state;
    t_state            n_state;
    t_result           eval_result;
    t_result           r_result;
    logic              eval_emit;
    logic              r_in_valid;
    logic [TIME_W-1:0] r_now;
    logic              r_raw;
    logic              r_out_valid;
    logic              advance;
    logic              in_accept;

    beq_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    beq_eval u_eval (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_now    (r_now),
        .i_raw    (r_raw),
        .o_state  (n_state),
        .o_emit   (eval_emit),
        .o_result (eval_result)
    );

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_state <= n_state;
            end

            if (advance && eval_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_now <= i_now_ms;
            r_raw <= i_raw_level;
        end
        if (advance && eval_emit) begin
            r_result <= eval_result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_is_down          = r_result.is_down;
    assign o_down_changed     = r_result.down_changed;
    assign o_change_period_ms = r_result.change_period_ms;
    assign o_repeat_count     = r_result.repeat_count;
    assign o_longpress_count  = r_result.longpress_count;

endmodule

// ----- src/beq_checker.sv -----
module beq_checker
    import beq_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic                 o_is_down,
    input logic                 o_down_changed,
    input logic [TIME_W-1:0]    o_change_period_ms,
    input logic [CNT_W-1:0]     o_repeat_count,
    input logic [CNT_W-1:0]     o_longpress_count
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_is_down)
            && $stable(o_down_changed) && $stable(o_change_period_ms)
            && $stable(o_repeat_count) && $stable(o_longpress_count))
        else $error("result beat changed while stalled");

    // no result beat without an earlier input beat offered or held in the input register
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid, 2) || $past(o_in_stall, 2)
            || $past(o_out_valid))
        else $error("result beat without input");

    // a level change restarts the long-press count
    a_change_clears_lp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_down_changed |-> o_longpress_count == '0)
        else $error("long-press count not cleared on change");

    // a result without level change is a long-press step while held
    a_lp_only_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_down_changed |-> o_is_down && (o_longpress_count != '0))
        else $error("long-press result while released");

endmodule

bind button_event_qualifier_top beq_checker u_beq_checker (.*);
